// ===== rtl/adll_pkg.sv =====
// Package with request and status codes and controller/datapath command types.
`default_nettype none
package adll_pkg;
  localparam int unsigned ReqW = 3;
  localparam int unsigned StW = 3;
  localparam int unsigned IdW = 30;
  localparam int unsigned NameW = 32;
  localparam int unsigned GradeW = 8;
  localparam int unsigned MaxResults = 16;

  typedef enum logic [2:0] {
    REQ_ADD_FIRST = 3'd0,
    REQ_ADD_AFTER = 3'd1,
    REQ_ADD_LAST = 3'd2,
    REQ_DEL_FIRST = 3'd3,
    REQ_DEL_AFTER = 3'd4,
    REQ_DEL_LAST = 3'd5,
    REQ_CLEAR = 3'd6,
    REQ_WALK = 3'd7
  } req_e;

  typedef enum logic [2:0] {
    ST_OK = 3'd0,
    ST_FULL = 3'd1,
    ST_EMPTY = 3'd2,
    ST_NOSUCC = 3'd3,
    ST_BADANCHOR = 3'd4
  } status_e;

  typedef struct packed {
    logic latch_req;
    logic exec;
    logic walk_first;
    logic walk_step;
    logic emit;
  } adll_cmd_t;

  typedef struct packed {
    logic is_walk;
    logic walk_done;
    logic out_busy;
  } adll_sts_t;
endpackage
`default_nettype wire

// ===== rtl/adll_if.sv =====
// Valid/ready channel interface carrying a generic payload.
`default_nettype none
interface adll_if #(
  parameter type payload_t = logic
);
  logic valid;
  logic ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/adll_ram.sv =====
// Generic single-port-write RAM with registered read.
`default_nettype none
module adll_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== rtl/adll_ctrl.sv =====
// Controller state machine sequencing requests and walks.
`default_nettype none
module adll_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire adll_pkg::adll_sts_t sts_i,
  output adll_pkg::adll_cmd_t      cmd_o
);
  import adll_pkg::*;
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;
  localparam logic [1:0] S_WRD = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch_req = 1'b1;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!sts_i.out_busy) begin
          if (sts_i.is_walk) begin
            cmd_o.walk_first = 1'b1;
            state_d = S_WRD;
          end else begin
            cmd_o.exec = 1'b1;
            cmd_o.emit = 1'b1;
            state_d = S_IDLE;
          end
        end
      end
      S_WRD: begin
        state_d = S_WALK;
      end
      S_WALK: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit = 1'b1;
          if (sts_i.walk_done) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.walk_step = 1'b1;
            state_d = S_WRD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end
endmodule
`default_nettype wire

// ===== rtl/adll_dp.sv =====
// Datapath: link tables, list registers, record memories and output register.
`default_nettype none
module adll_dp #(
  parameter int unsigned Capacity = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [2:0]          req_i,
  input  wire logic [3:0]          anchor_i,
  input  wire logic [29:0]         id_i,
  input  wire logic [31:0]         name_i,
  input  wire logic [7:0]          grade_i,
  input  wire adll_pkg::adll_cmd_t cmd_i,
  output adll_pkg::adll_sts_t      sts_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [2:0]               status_o,
  output logic [3:0]               slot_o,
  output logic [29:0]              out_id_o,
  output logic [31:0]              out_name_ref_o,
  output logic [7:0]               out_grade_o,
  output logic [4:0]               count_o,
  output logic                     last_o
);
  import adll_pkg::*;
  localparam int unsigned SW = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int unsigned CW = $clog2(Capacity + 1);

  logic [SW-1:0] next_q [Capacity];
  logic [SW-1:0] prev_q [Capacity];
  logic [Capacity-1:0] used_q, hasn_q;
  logic [SW-1:0] head_q, tail_q;
  logic [CW-1:0] cnt_q;

  logic [2:0] req_q;
  logic [3:0] anc_q;
  logic [29:0] id_q;
  logic [31:0] name_q;
  logic [7:0] grade_q;

  logic [SW-1:0] wslot_q;
  logic [4:0] wk_q;

  logic ov_q;
  logic [2:0] st_q;
  logic [3:0] slot_q;
  logic [4:0] cnt_out_q;
  logic last_q;
  logic walk_q;

  logic [SW-1:0] free_s;
  logic anc_in, anc_ok, full;
  logic [SW-1:0] anc_s;
  logic [4:0] cnt_ext;

  assign cnt_ext = 5'(cnt_q);
  assign anc_in = 32'(anc_q) < Capacity;
  assign anc_s = SW'(anc_q);
  assign anc_ok = anc_in && used_q[anc_s];
  assign full = 32'(cnt_q) >= Capacity;

  always_comb begin
    free_s = '0;
    for (int i = Capacity - 1; i >= 0; i--) begin
      if (!used_q[i]) free_s = SW'(i);
    end
  end

  logic we;
  logic [SW-1:0] raddr;
  logic [29:0] rid;
  logic [31:0] rname;
  logic [7:0] rgrade;
  assign raddr = cmd_i.walk_first ? head_q :
                 cmd_i.walk_step ? next_q[wslot_q] : wslot_q;

  adll_ram #(.Width(IdW), .Depth(Capacity)) u_id (
    .clk_i, .we_i(we), .waddr_i(free_s), .wdata_i(id_q),
    .raddr_i(raddr), .rdata_o(rid));
  adll_ram #(.Width(NameW), .Depth(Capacity)) u_name (
    .clk_i, .we_i(we), .waddr_i(free_s), .wdata_i(name_q),
    .raddr_i(raddr), .rdata_o(rname));
  adll_ram #(.Width(GradeW), .Depth(Capacity)) u_grade (
    .clk_i, .we_i(we), .waddr_i(free_s), .wdata_i(grade_q),
    .raddr_i(raddr), .rdata_o(rgrade));

  logic is_add;
  assign is_add = req_q == REQ_ADD_FIRST || req_q == REQ_ADD_AFTER || req_q == REQ_ADD_LAST;
  assign we = cmd_i.exec && is_add && !full &&
              !(req_q == REQ_ADD_AFTER && !anc_ok);

  logic walk_more;
  assign walk_more = hasn_q[wslot_q] && (wk_q + 5'd1 < cnt_ext) &&
                     (wk_q + 5'd1 < 5'(MaxResults));

  assign sts_o.is_walk = req_q == REQ_WALK && cnt_q != '0;
  assign sts_o.walk_done = !walk_more;
  assign sts_o.out_busy = ov_q && !out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_req) begin
      req_q <= req_i;
      anc_q <= anchor_i;
      id_q <= id_i;
      name_q <= name_i;
      grade_q <= grade_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic [SW-1:0] s, a, n;
    logic [2:0] st;
    logic [3:0] so;
    logic [CW-1:0] c;
    if (!rst_ni) begin
      used_q <= '0;
      hasn_q <= '0;
      head_q <= '0;
      tail_q <= '0;
      cnt_q <= '0;
      ov_q <= 1'b0;
      st_q <= ST_OK;
      slot_q <= '0;
      cnt_out_q <= '0;
      last_q <= 1'b0;
      walk_q <= 1'b0;
      wslot_q <= '0;
      wk_q <= '0;
    end else begin
      if (cmd_i.emit) ov_q <= 1'b1;
      else if (ov_q && out_ready_i) ov_q <= 1'b0;
      if (cmd_i.walk_first) begin
        wslot_q <= head_q;
        wk_q <= '0;
      end
      if (cmd_i.walk_step) begin
        wslot_q <= next_q[wslot_q];
        wk_q <= wk_q + 5'd1;
      end
      if (cmd_i.emit && !cmd_i.exec) begin
        st_q <= ST_OK;
        slot_q <= 4'(wslot_q);
        cnt_out_q <= cnt_ext;
        last_q <= !walk_more;
        walk_q <= 1'b1;
      end
      if (cmd_i.exec) begin
        st = ST_OK;
        so = '0;
        c = cnt_q;
        case (req_q)
          REQ_ADD_FIRST, REQ_ADD_AFTER, REQ_ADD_LAST: begin
            if (full) st = ST_FULL;
            else if (req_q == REQ_ADD_AFTER && !anc_ok) st = ST_BADANCHOR;
            else begin
              s = free_s;
              so = 4'(s);
              c = cnt_q + 1'b1;
              used_q[s] <= 1'b1;
              if (req_q == REQ_ADD_FIRST || cnt_q == '0) begin
                if (cnt_q == '0) begin
                  hasn_q[s] <= 1'b0;
                  tail_q <= s;
                end else begin
                  hasn_q[s] <= 1'b1;
                  next_q[s] <= head_q;
                  prev_q[head_q] <= s;
                end
                head_q <= s;
              end else begin
                a = (req_q == REQ_ADD_AFTER) ? anc_s : tail_q;
                prev_q[s] <= a;
                if (hasn_q[a]) begin
                  n = next_q[a];
                  next_q[s] <= n;
                  hasn_q[s] <= 1'b1;
                  prev_q[n] <= s;
                end else begin
                  hasn_q[s] <= 1'b0;
                  tail_q <= s;
                end
                next_q[a] <= s;
                hasn_q[a] <= 1'b1;
              end
            end
          end
          REQ_DEL_FIRST, REQ_DEL_LAST, REQ_DEL_AFTER: begin
            if (req_q != REQ_DEL_AFTER && cnt_q == '0) st = ST_EMPTY;
            else if (req_q == REQ_DEL_AFTER && !anc_ok) st = ST_BADANCHOR;
            else if (req_q == REQ_DEL_AFTER && !hasn_q[anc_s]) st = ST_NOSUCC;
            else if (req_q == REQ_DEL_FIRST ||
                     (req_q == REQ_DEL_LAST && cnt_q == CW'(1))) begin
              s = head_q;
              so = 4'(s);
              c = cnt_q - 1'b1;
              if (cnt_q <= CW'(1)) begin
                head_q <= '0;
                tail_q <= '0;
              end else begin
                head_q <= next_q[s];
              end
              used_q[s] <= 1'b0;
              hasn_q[s] <= 1'b0;
            end else begin
              a = (req_q == REQ_DEL_AFTER) ? anc_s : prev_q[tail_q];
              s = next_q[a];
              so = 4'(s);
              c = cnt_q - 1'b1;
              if (hasn_q[s]) begin
                n = next_q[s];
                next_q[a] <= n;
                prev_q[n] <= a;
              end else begin
                hasn_q[a] <= 1'b0;
                tail_q <= a;
              end
              used_q[s] <= 1'b0;
              hasn_q[s] <= 1'b0;
            end
          end
          REQ_CLEAR: begin
            used_q <= '0;
            hasn_q <= '0;
            head_q <= '0;
            tail_q <= '0;
            c = '0;
          end
          default: st = ST_EMPTY;
        endcase
        cnt_q <= c;
        st_q <= st;
        slot_q <= so;
        cnt_out_q <= 5'(c);
        last_q <= 1'b1;
        walk_q <= 1'b0;
      end
    end
  end

  logic [29:0] oid_q;
  logic [31:0] oname_q;
  logic [7:0] ogr_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      oid_q <= cmd_i.exec ? '0 : rid;
      oname_q <= cmd_i.exec ? '0 : rname;
      ogr_q <= cmd_i.exec ? '0 : rgrade;
    end
  end

  assign out_valid_o = ov_q;
  assign status_o = st_q;
  assign slot_o = slot_q;
  assign out_id_o = walk_q ? oid_q : '0;
  assign out_name_ref_o = walk_q ? oname_q : '0;
  assign out_grade_o = walk_q ? ogr_q : '0;
  assign count_o = cnt_out_q;
  assign last_o = last_q;
endmodule
`default_nettype wire

// ===== rtl/array_doubly_linked_list.sv =====
// Top level of the array-backed doubly linked list of student records.
// One request is taken, then executed: a list update delivers one result,
// loaded into the output register from the execute state; a walk emits
// up to sixteen results, each after the registered read of the record
// memories for each link followed. A stalled output holds the block. The
// next request is taken once the final result has been loaded into the
// output register. Slots are numbered from 0 to CAPACITY-1.
`default_nettype none
module array_doubly_linked_list #(
  parameter int unsigned CAPACITY = 16
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  adll_if.sink     in_if,
  adll_if.source   out_if
);
  import adll_pkg::*;
  adll_cmd_t cmd;
  adll_sts_t sts;

  adll_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .sts_i(sts), .cmd_o(cmd));

  adll_dp #(.Capacity(CAPACITY)) u_dp (
    .clk_i, .rst_ni,
    .req_i(in_if.data.req_type), .anchor_i(in_if.data.anchor_slot),
    .id_i(in_if.data.student_id), .name_i(in_if.data.name_ref),
    .grade_i(in_if.data.grade),
    .cmd_i(cmd), .sts_o(sts),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .status_o(out_if.data.status), .slot_o(out_if.data.slot),
    .out_id_o(out_if.data.out_id), .out_name_ref_o(out_if.data.out_name_ref),
    .out_grade_o(out_if.data.out_grade), .count_o(out_if.data.count),
    .last_o(out_if.data.last));
endmodule
`default_nettype wire

// ===== rtl/adll_chk.sv =====
// Port-level checker for the linked list block, bound to the top level.
`default_nettype none
module adll_chk (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [2:0] status,
  input wire logic [4:0] count,
  input wire logic       last
);
  import adll_pkg::*;
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> count <= 5'd16) else $error("count beyond capacity");
  a_fail_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && status != ST_OK |-> last) else $error("failure not final");
  a_accept_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready) else $error("back to back accept");
endmodule

bind array_doubly_linked_list adll_chk u_chk (
  .clk_i, .rst_ni, .in_valid(in_if.valid), .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready),
  .status(out_if.data.status), .count(out_if.data.count),
  .last(out_if.data.last));
`default_nettype wire
